/* src/capsule_point_cloud_hit_test_macros.svh */
// ----------------------------------------------------------------------------
// capsule_point_cloud_hit_test_macros
// assertion macros shared by the capsule hit test rtl
// ----------------------------------------------------------------------------
`ifndef CAPSULE_POINT_CLOUD_HIT_TEST_MACROS_SVH
`define CAPSULE_POINT_CLOUD_HIT_TEST_MACROS_SVH

// same-cycle implication on clk, ignored while rst is high
`define CPCHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, ignored while rst is high
`define CPCHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cpcht_pkg.sv */
// ----------------------------------------------------------------------------
// cpcht_pkg
// widths, register indexes and shared types of the capsule hit test
// ----------------------------------------------------------------------------
package cpcht_pkg;

  localparam int COORD_BITS = 20;
  localparam int HIT_LIMIT  = 3;
  localparam int HIT_SAT    = (HIT_LIMIT + 1 > 7) ? 7 : HIT_LIMIT + 1;
  localparam int CNT_W      = 3;
  localparam int LIMIT_W    = 4;
  localparam int LEN_SQ_MIN = 4295;
  localparam int RADIUS_W   = 16;
  localparam int CFG_W      = (COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W;
  localparam int IDX_W      = 3;

  // coordinate difference, sums of three products, limb split
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int WIDE_W = 2 * DIFF_W + 2;
  localparam int LO_W   = WIDE_W / 2;
  localparam int MUL_W  = (DIFF_W + 2 > RADIUS_W + 1) ? DIFF_W + 2 : RADIUS_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 2 * WIDE_W + 2;
  localparam int CHK_W  = WIDE_W + 5;

  localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_X   = 3'd3;
  localparam logic [IDX_W-1:0] REG_END_Y   = 3'd4;
  localparam logic [IDX_W-1:0] REG_END_Z   = 3'd5;
  localparam logic [IDX_W-1:0] REG_RADIUS  = 3'd6;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd5243;

  // product alignment inside the accumulator
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_LO   = 2'd1;
  localparam logic [1:0] SH_HI   = 2'd2;

  typedef struct packed {
    logic       en;
    logic       first;
    logic       sub;
    logic [1:0] shift;
  } mac_ctl_t;

  function automatic mac_ctl_t mac_op(input logic first, input logic sub,
                                      input logic [1:0] shift);
    mac_ctl_t c;
    c.en    = 1'b1;
    c.first = first;
    c.sub   = sub;
    c.shift = shift;
    return c;
  endfunction

  // low limb, zero extended to a positive multiplier operand
  function automatic logic signed [MUL_W-1:0] lo_limb(input logic signed [WIDE_W-1:0] v);
    return MUL_W'({1'b0, v[LO_W-1:0]});
  endfunction

  // high limb, sign extended
  function automatic logic signed [MUL_W-1:0] hi_limb(input logic signed [WIDE_W-1:0] v);
    return MUL_W'($signed(v[WIDE_W-1:LO_W]));
  endfunction

endpackage

/* src/cpcht_mac.sv */
// ----------------------------------------------------------------------------
// cpcht_mac
// shared signed multiplier with registered product and shifted accumulate
// ----------------------------------------------------------------------------
module cpcht_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cpcht_pkg::mac_ctl_t                   ctl,
  input  logic signed [cpcht_pkg::MUL_W-1:0]    op_a,
  input  logic signed [cpcht_pkg::MUL_W-1:0]    op_b,
  output logic signed [cpcht_pkg::ACC_W-1:0]    sum
);

  logic signed [cpcht_pkg::PROD_W-1:0] prod;
  cpcht_pkg::mac_ctl_t                 ctl_q;
  logic signed [cpcht_pkg::ACC_W-1:0]  acc;
  logic signed [cpcht_pkg::ACC_W-1:0]  prod_ext;
  logic signed [cpcht_pkg::ACC_W-1:0]  prod_sh;
  logic signed [cpcht_pkg::ACC_W-1:0]  base;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (ctl_q.en) begin
      acc <= sum;
    end
  end

  always_comb begin
    prod_ext = cpcht_pkg::ACC_W'(prod);
    unique case (ctl_q.shift)
      cpcht_pkg::SH_LO: prod_sh = prod_ext <<< cpcht_pkg::LO_W;
      cpcht_pkg::SH_HI: prod_sh = prod_ext <<< (2 * cpcht_pkg::LO_W);
      default:          prod_sh = prod_ext;
    endcase
    base = ctl_q.first ? '0 : acc;
    sum  = ctl_q.sub ? base - prod_sh : base + prod_sh;
  end

endmodule

/* src/capsule_point_cloud_hit_test.sv */
// ----------------------------------------------------------------------------
// capsule_point_cloud_hit_test
// capsule against streamed point cloud, one collision verdict per cloud
// ----------------------------------------------------------------------------
// Each transferred point is tested against the capsule given by the start,
// end and radius registers; the test is exact integer math with no division
// or root. One shared 23x23 signed multiplier with an accumulator does all
// eighteen products of a point (|AB|^2, AP.AB, |AP|^2 - r^2, then the two
// 88-bit products taken as four limb products each), one product per cycle.
// A point therefore holds point_ready low through its decide step, so a new
// point is taken only once the last one is through. A point with last_point
// set also holds it low in the send state until its result is loaded, which
// stalls while a previous result still waits for result_ready; the next
// cloud may start while a result waits. Configuration writes take effect at
// once and must only be made while no point is in flight.
// ----------------------------------------------------------------------------
`include "capsule_point_cloud_hit_test_macros.svh"

module capsule_point_cloud_hit_test (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration
  input  logic                                     cfg_wr_en,
  input  logic [cpcht_pkg::IDX_W-1:0]              cfg_index,
  input  logic [cpcht_pkg::CFG_W-1:0]              cfg_data,
  // point stream
  input  logic                                     point_valid,
  output logic                                     point_ready,
  input  logic signed [cpcht_pkg::COORD_BITS-1:0]  point_x,
  input  logic signed [cpcht_pkg::COORD_BITS-1:0]  point_y,
  input  logic signed [cpcht_pkg::COORD_BITS-1:0]  point_z,
  input  logic                                     last_point,
  // verdict
  output logic                                     result_valid,
  input  logic                                     result_ready,
  output logic                                     collision,
  output logic [cpcht_pkg::CNT_W-1:0]              hits_seen
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  // sequencer steps: first product of each group, last product and decide step
  localparam logic [4:0] S_LEN      = 5'd0;   // |AB|^2
  localparam logic [4:0] S_DOT      = 5'd3;   // AP.AB
  localparam logic [4:0] S_APSQ     = 5'd6;   // |AP|^2 - r^2
  localparam logic [4:0] S_DOTSQ    = 5'd10;  // minus dot^2, limb by limb
  localparam logic [4:0] S_ERRL2    = 5'd14;  // plus (|AP|^2 - r^2) * |AB|^2
  localparam logic [4:0] S_LAST_MUL = 5'd17;
  localparam logic [4:0] S_DECIDE   = 5'd18;

  // configuration registers
  logic signed [cpcht_pkg::COORD_BITS-1:0] start_x, start_y, start_z;
  logic signed [cpcht_pkg::COORD_BITS-1:0] end_x, end_y, end_z;
  logic [cpcht_pkg::RADIUS_W-1:0]          capsule_radius;

  // per-point working registers
  logic signed [cpcht_pkg::DIFF_W-1:0] ab_x, ab_y, ab_z;
  logic signed [cpcht_pkg::DIFF_W-1:0] ap_x, ap_y, ap_z;
  logic signed [cpcht_pkg::WIDE_W-1:0] len_sq;
  logic signed [cpcht_pkg::WIDE_W-1:0] dot;
  logic signed [cpcht_pkg::WIDE_W-1:0] err;
  logic                                reject;
  logic                                last_q;

  logic [1:0]                  state;
  logic [4:0]                  step;
  logic [cpcht_pkg::CNT_W-1:0] hit_counter;
  logic                        load_result;

  // shared unit
  cpcht_pkg::mac_ctl_t                 ctl;
  logic signed [cpcht_pkg::MUL_W-1:0]  op_a, op_b;
  logic signed [cpcht_pkg::ACC_W-1:0]  sum;

  // projection window and degenerate segment checks
  logic signed [cpcht_pkg::CHK_W-1:0] dot_x20, len_x21, len_ext;
  logic                               hit;

  assign point_ready = (state == ST_IDLE);
  assign load_result = (state == ST_SEND) && (!result_valid || result_ready);

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x        <= '0;
      start_y        <= '0;
      start_z        <= '0;
      end_x          <= '0;
      end_y          <= '0;
      end_z          <= '0;
      capsule_radius <= cpcht_pkg::RADIUS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cpcht_pkg::REG_START_X: start_x <= cfg_data[cpcht_pkg::COORD_BITS-1:0];
        cpcht_pkg::REG_START_Y: start_y <= cfg_data[cpcht_pkg::COORD_BITS-1:0];
        cpcht_pkg::REG_START_Z: start_z <= cfg_data[cpcht_pkg::COORD_BITS-1:0];
        cpcht_pkg::REG_END_X:   end_x   <= cfg_data[cpcht_pkg::COORD_BITS-1:0];
        cpcht_pkg::REG_END_Y:   end_y   <= cfg_data[cpcht_pkg::COORD_BITS-1:0];
        cpcht_pkg::REG_END_Z:   end_z   <= cfg_data[cpcht_pkg::COORD_BITS-1:0];
        cpcht_pkg::REG_RADIUS:  capsule_radius <= cfg_data[cpcht_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // operand and accumulate control per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    ctl  = '0;
    if (state == ST_CALC) begin
      unique case (step)
        S_LEN: begin
          op_a = cpcht_pkg::MUL_W'(ab_x);
          op_b = cpcht_pkg::MUL_W'(ab_x);
          ctl  = cpcht_pkg::mac_op(1'b1, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_LEN + 5'd1: begin
          op_a = cpcht_pkg::MUL_W'(ab_y);
          op_b = cpcht_pkg::MUL_W'(ab_y);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_LEN + 5'd2: begin
          op_a = cpcht_pkg::MUL_W'(ab_z);
          op_b = cpcht_pkg::MUL_W'(ab_z);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_DOT: begin
          op_a = cpcht_pkg::MUL_W'(ap_x);
          op_b = cpcht_pkg::MUL_W'(ab_x);
          ctl  = cpcht_pkg::mac_op(1'b1, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_DOT + 5'd1: begin
          op_a = cpcht_pkg::MUL_W'(ap_y);
          op_b = cpcht_pkg::MUL_W'(ab_y);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_DOT + 5'd2: begin
          op_a = cpcht_pkg::MUL_W'(ap_z);
          op_b = cpcht_pkg::MUL_W'(ab_z);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_APSQ: begin
          op_a = cpcht_pkg::MUL_W'(ap_x);
          op_b = cpcht_pkg::MUL_W'(ap_x);
          ctl  = cpcht_pkg::mac_op(1'b1, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_APSQ + 5'd1: begin
          op_a = cpcht_pkg::MUL_W'(ap_y);
          op_b = cpcht_pkg::MUL_W'(ap_y);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_APSQ + 5'd2: begin
          op_a = cpcht_pkg::MUL_W'(ap_z);
          op_b = cpcht_pkg::MUL_W'(ap_z);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_APSQ + 5'd3: begin
          // subtract r^2
          op_a = cpcht_pkg::MUL_W'({1'b0, capsule_radius});
          op_b = cpcht_pkg::MUL_W'({1'b0, capsule_radius});
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b1, cpcht_pkg::SH_NONE);
        end
        S_DOTSQ: begin
          op_a = cpcht_pkg::lo_limb(dot);
          op_b = cpcht_pkg::lo_limb(dot);
          ctl  = cpcht_pkg::mac_op(1'b1, 1'b1, cpcht_pkg::SH_NONE);
        end
        S_DOTSQ + 5'd1: begin
          op_a = cpcht_pkg::hi_limb(dot);
          op_b = cpcht_pkg::lo_limb(dot);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b1, cpcht_pkg::SH_LO);
        end
        S_DOTSQ + 5'd2: begin
          op_a = cpcht_pkg::lo_limb(dot);
          op_b = cpcht_pkg::hi_limb(dot);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b1, cpcht_pkg::SH_LO);
        end
        S_DOTSQ + 5'd3: begin
          op_a = cpcht_pkg::hi_limb(dot);
          op_b = cpcht_pkg::hi_limb(dot);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b1, cpcht_pkg::SH_HI);
        end
        S_ERRL2: begin
          op_a = cpcht_pkg::lo_limb(err);
          op_b = cpcht_pkg::lo_limb(len_sq);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_NONE);
        end
        S_ERRL2 + 5'd1: begin
          op_a = cpcht_pkg::hi_limb(err);
          op_b = cpcht_pkg::lo_limb(len_sq);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_LO);
        end
        S_ERRL2 + 5'd2: begin
          op_a = cpcht_pkg::lo_limb(err);
          op_b = cpcht_pkg::hi_limb(len_sq);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_LO);
        end
        S_LAST_MUL: begin
          op_a = cpcht_pkg::hi_limb(err);
          op_b = cpcht_pkg::hi_limb(len_sq);
          ctl  = cpcht_pkg::mac_op(1'b0, 1'b0, cpcht_pkg::SH_HI);
        end
        default: ;
      endcase
    end
  end

  cpcht_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .op_a (op_a),
    .op_b (op_b),
    .sum  (sum)
  );

  // t window: 20*dot + L2 >= 0 and 21*L2 - 20*dot >= 0
  always_comb begin
    len_ext = cpcht_pkg::CHK_W'(len_sq);
    dot_x20 = (cpcht_pkg::CHK_W'(dot) <<< 4) + (cpcht_pkg::CHK_W'(dot) <<< 2);
    len_x21 = (len_ext <<< 4) + (len_ext <<< 2) + len_ext;
  end

  // sum at the decide step is (|AP|^2 - r^2)*L2 - dot^2
  assign hit = sum[cpcht_pkg::ACC_W-1] && !reject;

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (point_valid && point_ready) begin
      ab_x   <= cpcht_pkg::DIFF_W'(end_x) - cpcht_pkg::DIFF_W'(start_x);
      ab_y   <= cpcht_pkg::DIFF_W'(end_y) - cpcht_pkg::DIFF_W'(start_y);
      ab_z   <= cpcht_pkg::DIFF_W'(end_z) - cpcht_pkg::DIFF_W'(start_z);
      ap_x   <= cpcht_pkg::DIFF_W'(point_x) - cpcht_pkg::DIFF_W'(start_x);
      ap_y   <= cpcht_pkg::DIFF_W'(point_y) - cpcht_pkg::DIFF_W'(start_y);
      ap_z   <= cpcht_pkg::DIFF_W'(point_z) - cpcht_pkg::DIFF_W'(start_z);
      last_q <= last_point;
    end
    // group results are captured from sum in the step after their last product issues
    if (state == ST_CALC && step == S_DOT) begin
      len_sq <= sum[cpcht_pkg::WIDE_W-1:0];
    end
    if (state == ST_CALC && step == S_APSQ) begin
      dot <= sum[cpcht_pkg::WIDE_W-1:0];
    end
    if (state == ST_CALC && step == S_DOTSQ) begin
      err <= sum[cpcht_pkg::WIDE_W-1:0];
    end
    // settles well before the decide step
    reject <= (len_sq < cpcht_pkg::WIDE_W'(cpcht_pkg::LEN_SQ_MIN))
              || ((dot_x20 + len_ext) < 0)
              || ((len_x21 - dot_x20) < 0);
    if (load_result) begin
      collision <= {1'b0, hit_counter} > cpcht_pkg::LIMIT_W'(cpcht_pkg::HIT_LIMIT);
      hits_seen <= hit_counter;
    end
  end

  // sequencer, hit counter and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= S_LEN;
      hit_counter  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !load_result) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (point_valid) begin
            state <= ST_CALC;
            step  <= S_LEN;
          end
        end
        ST_CALC: begin
          step <= step + 5'd1;
          if (step == S_DECIDE) begin
            if (hit && hit_counter < cpcht_pkg::CNT_W'(cpcht_pkg::HIT_SAT)) begin
              hit_counter <= hit_counter + 1'b1;
            end
            state <= last_q ? ST_SEND : ST_IDLE;
          end
        end
        ST_SEND: begin
          // wait until the result register is free
          if (load_result) begin
            result_valid <= 1'b1;
            hit_counter  <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CPCHT_ASSERT_NEXT(a_transfer_starts_calc, point_valid && point_ready, state == ST_CALC && step == S_LEN, "point transfer did not start the sequence")
  `CPCHT_ASSERT_NOW(a_counter_saturates, 1'b1, hit_counter <= cpcht_pkg::CNT_W'(cpcht_pkg::HIT_SAT), "hit counter passed its saturation value")
  `CPCHT_ASSERT_NOW(a_verdict_matches_count, result_valid, collision == ({1'b0, hits_seen} > cpcht_pkg::LIMIT_W'(cpcht_pkg::HIT_LIMIT)), "collision flag disagrees with hit count")
  `CPCHT_ASSERT_NOW(a_result_from_send, $rose(result_valid), $past(state) == ST_SEND, "result appeared outside the send state")
  `CPCHT_ASSERT_NEXT(a_counter_cleared, load_result, hit_counter == '0, "hit counter not cleared after result")

endmodule

/* tb/sv/capsule_point_cloud_hit_test_tb.sv */
// ----------------------------------------------------------------------------
// capsule_point_cloud_hit_test_tb
// self-checking bench for the capsule against point cloud hit test
// ----------------------------------------------------------------------------
// Streams clouds of points through the block under several capsule settings
// and compares every verdict with a local model that redoes the projection
// window, the degenerate check and the squared-distance test in wide signed
// integers. Directed clouds hit the window edges, the radius edge, counter
// saturation, tiny segments, zero radius and a rewrite in the middle of a
// cloud; random clouds follow, mostly points scattered around the segment.
// Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module capsule_point_cloud_hit_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = cpcht_pkg::COORD_BITS;
  localparam longint COORD_MAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (CB - 1));
  // a point holds the block through its sequence, a last point until its result loads
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int POINTS_PER_PHASE = 200;
  localparam int MAX_REPORTS = 10;

  // wide enough for every product of the hit test without overflow
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic                        collision;
    logic [cpcht_pkg::CNT_W-1:0] hits;
  } verdict_t;

  // shapes of capsule used by the random phases
  typedef enum int {
    CAP_RANDOM, CAP_CORNERS, CAP_TINY, CAP_NO_RADIUS, CAP_WILD, CAP_THIN
  } cap_kind_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [cpcht_pkg::IDX_W-1:0]  cfg_index;
  logic [cpcht_pkg::CFG_W-1:0]  cfg_data;
  logic                         point_valid;
  logic                         point_ready;
  logic signed [CB-1:0]         point_x;
  logic signed [CB-1:0]         point_y;
  logic signed [CB-1:0]         point_z;
  logic                         last_point;
  logic                         result_valid;
  logic                         result_ready;
  logic                         collision;
  logic [cpcht_pkg::CNT_W-1:0]  hits_seen;

  // local copy of the capsule registers and the running hit count
  logic signed [CB-1:0]             seg_start [3];
  logic signed [CB-1:0]             seg_end [3];
  logic [cpcht_pkg::RADIUS_W-1:0]   cap_radius;
  int                               cloud_hits;

  verdict_t verdict_q[$];
  verdict_t verdict_due;
  int       mismatch_count;
  bit       steady_feed;

  capsule_point_cloud_hit_test u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .last_point   (last_point),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .collision    (collision),
    .hits_seen    (hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // model of the hit test
  // ---------------------------------------------------------------------------

  // true when the segment is not degenerate, the point projects inside the
  // widened segment and it lies strictly closer than the radius to the segment line
  function automatic logic point_in_capsule(input logic signed [CB-1:0] px, py, pz);
    wide_t s [3];
    wide_t e [3];
    wide_t p [3];
    wide_t ab [3];
    wide_t ap [3];
    wide_t len_sq;
    wide_t dot;
    wide_t ap_sq;
    wide_t rad;
    int    a;
    p[0] = wide_t'(px);
    p[1] = wide_t'(py);
    p[2] = wide_t'(pz);
    len_sq = 0;
    dot = 0;
    ap_sq = 0;
    for (a = 0; a < 3; a++) begin
      s[a] = wide_t'(seg_start[a]);
      e[a] = wide_t'(seg_end[a]);
      ab[a] = e[a] - s[a];
      ap[a] = p[a] - s[a];
      len_sq = len_sq + ab[a] * ab[a];
      dot = dot + ap[a] * ab[a];
      ap_sq = ap_sq + ap[a] * ap[a];
    end
    // segment too short to define a direction
    if (len_sq < cpcht_pkg::LEN_SQ_MIN) return 1'b0;
    // projection before -0.05 or past 1.05 of the segment
    if (20 * dot + len_sq < 0) return 1'b0;
    if (21 * len_sq - 20 * dot < 0) return 1'b0;
    rad = wide_t'(cap_radius);
    return (ap_sq * len_sq - dot * dot < rad * rad * len_sq);
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  function automatic longint rand_span(input longint lo, input longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  function automatic logic signed [CB-1:0] clamp_coord(input longint v);
    if (v > COORD_MAX) return CB'(COORD_MAX);
    if (v < COORD_MIN) return CB'(COORD_MIN);
    return v[CB-1:0];
  endfunction

  function automatic logic signed [CB-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    return r[CB-1:0];
  endfunction

  // values at the rails of the coordinate range and around zero
  function automatic logic signed [CB-1:0] rail_coord();
    case ($urandom_range(0, 4))
      0: return CB'(COORD_MIN);
      1: return CB'(COORD_MAX);
      2: return '0;
      3: return '1;
      default: return CB'(1);
    endcase
  endfunction

  // one axis of a point at parameter t/1024 along the segment, jittered by
  // up to +-spread
  function automatic logic signed [CB-1:0] near_coord(input int a, input longint t,
                                                      input longint spread);
    longint s;
    longint e;
    s = longint'(seg_start[a]);
    e = longint'(seg_end[a]);
    return clamp_coord(s + (e - s) * t / 1024 + rand_span(-spread, spread));
  endfunction

  // idle cycles before the next point, mostly short and a few long
  function automatic int feed_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_feed || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus primitives
  // ---------------------------------------------------------------------------

  // one point transfer, then update of the model; valid stays high when the
  // next point follows without a gap
  task automatic send_point(input logic signed [CB-1:0] x, y, z, input logic last);
    int gap;
    gap = feed_gap();
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_valid <= 1'b1;
    point_x     <= x;
    point_y     <= y;
    point_z     <= z;
    last_point  <= last;
    do @(posedge clk); while (!point_ready);
    if (point_in_capsule(x, y, z) && cloud_hits < cpcht_pkg::HIT_SAT) cloud_hits++;
    if (last) begin
      verdict_due.collision = (cloud_hits > cpcht_pkg::HIT_LIMIT);
      verdict_due.hits      = cpcht_pkg::CNT_W'(cloud_hits);
      verdict_q = {verdict_q, verdict_due};
      cloud_hits = 0;
    end
  endtask

  // stop feeding, let every verdict come back and the last point drain
  task automatic wait_idle();
    point_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all seven registers, one per cycle; the model follows each write
  // at the edge that takes it
  task automatic load_capsule(input logic signed [CB-1:0] sx, sy, sz, ex, ey, ez,
                              input logic [cpcht_pkg::CFG_W-1:0] radius_word);
    logic [cpcht_pkg::CFG_W-1:0] word [cpcht_pkg::REG_RADIUS+1];
    int                          k;
    word[cpcht_pkg::REG_START_X] = sx;
    word[cpcht_pkg::REG_START_Y] = sy;
    word[cpcht_pkg::REG_START_Z] = sz;
    word[cpcht_pkg::REG_END_X]   = ex;
    word[cpcht_pkg::REG_END_Y]   = ey;
    word[cpcht_pkg::REG_END_Z]   = ez;
    word[cpcht_pkg::REG_RADIUS]  = radius_word;
    for (k = cpcht_pkg::REG_START_X; k <= cpcht_pkg::REG_RADIUS; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cpcht_pkg::IDX_W'(k);
      cfg_data  <= word[k];
      @(posedge clk);
      case (k)
        cpcht_pkg::REG_START_X: seg_start[0] = word[k][CB-1:0];
        cpcht_pkg::REG_START_Y: seg_start[1] = word[k][CB-1:0];
        cpcht_pkg::REG_START_Z: seg_start[2] = word[k][CB-1:0];
        cpcht_pkg::REG_END_X:   seg_end[0]   = word[k][CB-1:0];
        cpcht_pkg::REG_END_Y:   seg_end[1]   = word[k][CB-1:0];
        cpcht_pkg::REG_END_Z:   seg_end[2]   = word[k][CB-1:0];
        cpcht_pkg::REG_RADIUS:  cap_radius   = word[k][cpcht_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // reset registers give a zero-length segment, so nothing can hit
  task automatic test_default_registers();
    send_point(CB'(COORD_MIN), CB'(COORD_MIN), CB'(COORD_MIN), 1'b0);
    send_point(CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX), 1'b1);
  endtask

  // segment of 4 m along x, radius just under 1 m written with junk in the
  // bits above the radius width
  task automatic test_projection_window();
    wait_idle();
    load_capsule(0, 0, 0, 262144, 0, 0, {cpcht_pkg::CFG_W{1'b1}});
    // t just inside and just outside -0.05
    send_point(-13107, 0, 0, 1'b0);
    send_point(-13108, 0, 0, 1'b0);
    // t just inside and just outside 1.05
    send_point(275251, 0, 0, 1'b0);
    send_point(275252, 0, 0, 1'b0);
    // exactly on the radius is a miss, one unit inside is a hit
    send_point(131072, 65535, 0, 1'b0);
    send_point(131072, 65534, 0, 1'b1);
  endtask

  // five hits in one cloud, the count stops at the limit plus one
  task automatic test_hit_saturation();
    int n;
    for (n = 0; n < 5; n++) send_point(CB'(n * 65536), 0, 0, n == 4);
  endtask

  // squared length just below and just above the degenerate threshold,
  // then a zero radius on a long segment
  task automatic test_degenerate_and_zero_radius();
    wait_idle();
    load_capsule(0, 0, 0, 65, 0, 0, 16'hFFFF);
    send_point(32, 0, 0, 1'b1);
    wait_idle();
    load_capsule(0, 0, 0, 66, 0, 0, 16'hFFFF);
    send_point(33, 0, 0, 1'b1);
    wait_idle();
    load_capsule(0, 0, 0, 262144, 0, 0, '0);
    send_point(131072, 0, 0, 1'b1);
  endtask

  // capsule changes between two points of one cloud; the second point sits
  // on the diagonal from the lowest to the highest corner
  task automatic test_midcloud_rewrite();
    wait_idle();
    load_capsule(0, 0, 0, 262144, 0, 0, 16'hFFFF);
    send_point(131072, 0, 0, 1'b0);
    wait_idle();
    load_capsule(CB'(COORD_MIN), CB'(COORD_MIN), CB'(COORD_MIN),
                 CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX), 16'hFFFF);
    send_point(0, 0, 0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // random clouds
  // ---------------------------------------------------------------------------

  task automatic test_random_clouds();
    cap_kind_t                   kind;
    logic signed [CB-1:0]        s [3];
    logic signed [CB-1:0]        e [3];
    logic [cpcht_pkg::CFG_W-1:0] radius_word;
    logic signed [CB-1:0]        c [3];
    longint                      t;
    longint                      spread;
    int                          phase;
    int                          n;
    int                          a;
    int                          roll;
    int                          cloud_len;
    int                          cloud_pos;
    cloud_len = 0;
    cloud_pos = 0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = cap_kind_t'(phase % 6);
      if (phase == 6) kind = CAP_CORNERS;
      if (phase == 7) kind = CAP_WILD;
      radius_word = cpcht_pkg::CFG_W'($urandom);
      radius_word[cpcht_pkg::RADIUS_W-1:0] = cpcht_pkg::RADIUS_W'($urandom_range(1000, 65535));
      for (a = 0; a < 3; a++) begin
        s[a] = CB'(rand_span(-300000, 300000));
        e[a] = CB'(rand_span(-300000, 300000));
      end
      case (kind)
        CAP_CORNERS: begin
          for (a = 0; a < 3; a++) begin
            s[a] = $urandom_range(0, 1) ? CB'(COORD_MAX) : CB'(COORD_MIN);
            e[a] = $urandom_range(0, 1) ? CB'(COORD_MAX) : CB'(COORD_MIN);
          end
          if ($urandom_range(0, 1)) radius_word[cpcht_pkg::RADIUS_W-1:0] = '1;
        end
        CAP_TINY: begin
          // squared length straddles the degenerate threshold
          for (a = 0; a < 3; a++) e[a] = CB'(longint'(s[a]) + rand_span(-45, 45));
          radius_word[cpcht_pkg::RADIUS_W-1:0] = cpcht_pkg::RADIUS_W'($urandom_range(0, 65535));
        end
        CAP_NO_RADIUS: radius_word[cpcht_pkg::RADIUS_W-1:0] = '0;
        CAP_WILD: begin
          for (a = 0; a < 3; a++) begin
            s[a] = rand_coord();
            e[a] = rand_coord();
          end
        end
        CAP_THIN: radius_word[cpcht_pkg::RADIUS_W-1:0] = cpcht_pkg::RADIUS_W'($urandom_range(0, 2000));
        default: ;
      endcase
      // rewrite while a cloud may still be open
      wait_idle();
      load_capsule(s[0], s[1], s[2], e[0], e[1], e[2], radius_word);
      for (n = 0; n < POINTS_PER_PHASE; n++) begin
        if (n % 50 == 0) steady_feed = ($urandom_range(0, 4) == 0);
        if (cloud_pos == cloud_len) begin
          roll = $urandom_range(0, 99);
          if (roll < 15) cloud_len = 1;
          else if (roll < 85) cloud_len = $urandom_range(2, 8);
          else cloud_len = $urandom_range(9, 20);
          cloud_pos = 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          // scattered around the segment, mostly well inside the radius
          t = rand_span(-100, 1124);
          spread = longint'(cap_radius);
          spread = ($urandom_range(0, 3) == 0) ? spread + spread / 2 : spread / 2;
          for (a = 0; a < 3; a++) c[a] = near_coord(a, t, spread);
        end else if (roll < 88) begin
          for (a = 0; a < 3; a++) c[a] = rand_coord();
        end else begin
          for (a = 0; a < 3; a++) c[a] = rail_coord();
        end
        cloud_pos++;
        send_point(c[0], c[1], c[2], cloud_pos == cloud_len);
      end
    end
    steady_feed = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // verdict side
  // ---------------------------------------------------------------------------

  // receiver stalls: runs of ready, short stalls and the odd long one
  initial begin
    int run;
    int mode;
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        result_ready <= 1'b1;
        run = $urandom_range(1, 40);
      end else if (mode < 9) begin
        result_ready <= 1'b0;
        run = $urandom_range(1, 4);
      end else begin
        result_ready <= 1'b0;
        run = $urandom_range(20, 60);
      end
      repeat (run) @(posedge clk);
    end
  end

  // each verdict transfer is matched against the oldest predicted verdict
  verdict_t verdict_want;
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (verdict_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected verdict: collision=%0b hits_seen=%0d", collision, hits_seen);
        mismatch_count++;
      end else begin
        verdict_want = verdict_q.pop_front();
        if (collision !== verdict_want.collision || hits_seen !== verdict_want.hits) begin
          if (mismatch_count < MAX_REPORTS)
            $display("verdict mismatch: expected collision=%0b hits_seen=%0d, got %0b %0d",
                     verdict_want.collision, verdict_want.hits, collision, hits_seen);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    point_valid <= 1'b0;
    point_x     <= '0;
    point_y     <= '0;
    point_z     <= '0;
    last_point  <= 1'b0;
    // model state after reset
    for (int a = 0; a < 3; a++) begin
      seg_start[a] = '0;
      seg_end[a]   = '0;
    end
    cap_radius     = cpcht_pkg::RADIUS_RESET;
    cloud_hits     = 0;
    mismatch_count = 0;
    steady_feed    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_registers();
    test_projection_window();
    test_hit_saturation();
    test_degenerate_and_zero_radius();
    test_midcloud_rewrite();
    test_random_clouds();

    // everything sent: let the last verdicts arrive and any stray one show
    wait_idle();
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("capsule_point_cloud_hit_test_tb passed");
    end else begin
      $display("capsule_point_cloud_hit_test_tb failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #20ms;
    $display("capsule_point_cloud_hit_test_tb failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/cpcht_pkg.sv
src/cpcht_mac.sv
src/capsule_point_cloud_hit_test.sv
tb/sv/capsule_point_cloud_hit_test_tb.sv
